// ===== sv/uart_frame_to_spi_bridge_unit_macros.svh =====
// Assertion macros shared by the bridge RTL.
`ifndef UART_FRAME_TO_SPI_BRIDGE_UNIT_MACROS_SVH
`define UART_FRAME_TO_SPI_BRIDGE_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define UFSB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define UFSB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== sv/ufsb_pkg.sv =====
// Types and constants of the frame-to-SPI bridge.
`timescale 1ns / 1ps
`default_nettype none

package ufsb_pkg;

  localparam logic [9:0] OffSr   = 10'd0;
  localparam logic [9:0] OffDr   = 10'd4;
  localparam logic [9:0] OffBrr  = 10'd8;
  localparam logic [9:0] OffCr1  = 10'd12;
  localparam logic [9:0] OffCr2  = 10'd16;
  localparam logic [9:0] OffCr3  = 10'd20;
  localparam logic [9:0] OffGtpr = 10'd24;

  localparam logic       OpRead  = 1'b0;

  localparam logic [9:0] SrReset = 10'h0C0;
  localparam logic [9:0] SrTxe   = 10'h080;
  localparam logic [9:0] SrTc    = 10'h040;
  localparam logic [9:0] SrRxne  = 10'h020;
  localparam logic [9:0] SrMask  = 10'h3FF;
  localparam int unsigned RxneBit   = 5;
  localparam int unsigned RxneIeBit = 5;
  localparam int unsigned LongFrameBit = 7;

  localparam logic [63:0] ReplyValue = 64'h50FF010000000000;

  // Selects at or above this count are flagged instead of asserted.
  localparam int unsigned NumSelects = 4;

  typedef struct packed {
    logic        operation;
    logic [9:0]  reg_offset;
    logic [31:0] write_data;
    logic        byte_access;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        spi_valid;
    logic [31:0] spi_word;
    logic [1:0]  chip_select;
    logic        select_error;
    logic        last;
  } out_item_t;

  // Work handed from the front to the back through the queue.
  typedef struct packed {
    logic        frame_done;
    logic [31:0] read_data;
    logic        irq_level;
    logic [63:0] frame;
    logic [1:0]  chip_select;
    logic        select_error;
  } job_t;

  function automatic logic [7:0] reply_byte(logic [2:0] idx);
    logic [5:0] sh;
    sh = {~idx, 3'b000};
    return ReplyValue[sh +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== sv/ufsb_queue.sv =====
// Short job queue between the register front and the result back end.
`timescale 1ns / 1ps
`default_nettype none

module ufsb_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ufsb_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output ufsb_pkg::job_t     data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ufsb_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ufsb_front.sv =====
// Register front: decodes each bus access, updates register and frame state.
`timescale 1ns / 1ps
`default_nettype none

module ufsb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ufsb_pkg::in_item_t in_item_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output ufsb_pkg::job_t         q_job_o
);

  logic [9:0]  status_q, status_d;
  logic [31:0] baud_q, baud_d, cr1_q, cr1_d, cr2_q, cr2_d;
  logic [31:0] cr3_q, cr3_d, gtpr_q, gtpr_d;
  logic [7:0]  frame_q [8];
  logic [7:0]  frame_d [8];
  logic [3:0]  fidx_q, fidx_d, flen_q, flen_d, ridx_q, ridx_d;
  logic        irq_q, irq_d;

  logic        accept, done;
  logic [31:0] rdata, value;
  logic [3:0]  nidx, nlen;
  logic [9:0]  st;
  logic [7:0]  sel;
  logic        sel_err;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign value      = in_item_i.write_data;

  always_comb begin
    status_d = status_q;
    baud_d   = baud_q;
    cr1_d    = cr1_q;
    cr2_d    = cr2_q;
    cr3_d    = cr3_q;
    gtpr_d   = gtpr_q;
    frame_d  = frame_q;
    fidx_d   = fidx_q;
    flen_d   = flen_q;
    ridx_d   = ridx_q;
    irq_d    = irq_q;
    done     = 1'b0;
    rdata    = '0;
    nidx     = fidx_q + 4'd1;
    nlen     = flen_q;
    st       = status_q;
    if (accept) begin
      if (in_item_i.operation == ufsb_pkg::OpRead) begin
        case (in_item_i.reg_offset)
          ufsb_pkg::OffSr: begin
            rdata = {22'd0, status_q};
          end
          ufsb_pkg::OffDr: begin
            if (!ridx_q[3]) begin
              rdata  = {24'd0, ufsb_pkg::reply_byte(ridx_q[2:0])};
              ridx_d = ridx_q + 4'd1;
              if (ridx_q == 4'd7) begin
                status_d = status_q & ~ufsb_pkg::SrRxne;
              end
            end
          end
          ufsb_pkg::OffBrr:  rdata = baud_q;
          ufsb_pkg::OffCr1:  rdata = cr1_q;
          ufsb_pkg::OffCr2:  rdata = cr2_q;
          ufsb_pkg::OffCr3:  rdata = cr3_q;
          ufsb_pkg::OffGtpr: rdata = gtpr_q;
          default:           rdata = '0;
        endcase
      end else begin
        case (in_item_i.reg_offset)
          ufsb_pkg::OffSr: begin
            if (value <= {22'd0, ufsb_pkg::SrMask}) begin
              st = value[9:0] | ufsb_pkg::SrTxe;
            end else begin
              st = status_q & value[9:0];
            end
            status_d = st;
            if (!st[ufsb_pkg::RxneBit]) begin
              irq_d = 1'b0;
            end
          end
          ufsb_pkg::OffDr: begin
            // a leading zero byte written by a byte access is not stored in the frame
            if (!(fidx_q == 4'd0 && value == '0 && in_item_i.byte_access)) begin
              frame_d[fidx_q[2:0]] = value[7:0];
              if (nidx == 4'd3) begin
                nlen = value[ufsb_pkg::LongFrameBit] ? 4'd8 : 4'd4;
              end
              flen_d = nlen;
              if (nidx >= nlen) begin
                fidx_d   = 4'd0;
                done     = 1'b1;
                ridx_d   = 4'd4;
                status_d = status_q | ufsb_pkg::SrRxne | ufsb_pkg::SrTc;
                if (cr1_q[ufsb_pkg::RxneIeBit]) begin
                  irq_d = 1'b1;
                end
              end else begin
                fidx_d   = nidx;
                status_d = status_q | ufsb_pkg::SrTc;
              end
            end
          end
          ufsb_pkg::OffBrr: baud_d = value;
          ufsb_pkg::OffCr1: begin
            cr1_d = value;
            if (value[ufsb_pkg::RxneIeBit] && status_q[ufsb_pkg::RxneBit]) begin
              irq_d = 1'b1;
            end
          end
          ufsb_pkg::OffCr2:  cr2_d  = value;
          ufsb_pkg::OffCr3:  cr3_d  = value;
          ufsb_pkg::OffGtpr: gtpr_d = value;
          default: begin
          end
        endcase
      end
    end
  end

  assign sel     = frame_d[1];
  assign sel_err = (sel >= 8'(ufsb_pkg::NumSelects));

  assign q_push_o = accept;
  always_comb begin
    q_job_o.frame_done   = done;
    q_job_o.read_data    = rdata;
    q_job_o.irq_level    = irq_d;
    q_job_o.frame        = {frame_d[0], frame_d[1], frame_d[2], frame_d[3],
                            frame_d[4], frame_d[5], frame_d[6], frame_d[7]};
    q_job_o.chip_select  = sel_err ? 2'd0 : sel[1:0];
    q_job_o.select_error = sel_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ufsb_pkg::SrReset;
      baud_q   <= '0;
      cr1_q    <= '0;
      cr2_q    <= '0;
      cr3_q    <= '0;
      gtpr_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        frame_q[i] <= '0;
      end
      fidx_q   <= 4'd0;
      flen_q   <= 4'd4;
      ridx_q   <= 4'd8;
      irq_q    <= 1'b0;
    end else begin
      status_q <= status_d;
      baud_q   <= baud_d;
      cr1_q    <= cr1_d;
      cr2_q    <= cr2_d;
      cr3_q    <= cr3_d;
      gtpr_q   <= gtpr_d;
      frame_q  <= frame_d;
      fidx_q   <= fidx_d;
      flen_q   <= flen_d;
      ridx_q   <= ridx_d;
      irq_q    <= irq_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ufsb_back.sv =====
// Result back end: turns queued jobs into one or two output items.
`timescale 1ns / 1ps
`default_nettype none

module ufsb_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire ufsb_pkg::job_t q_job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ufsb_pkg::out_item_t out_item_o
);

  logic                out_valid_q, out_valid_d;
  ufsb_pkg::out_item_t out_q, out_d;
  logic                phase_q, phase_d;
  logic                load;

  // output register frees up when empty or being taken
  assign load    = !q_empty_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = load && (!q_job_i.frame_done || phase_q);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    phase_d     = phase_q;
    if (load) begin
      out_valid_d        = 1'b1;
      out_d.irq_level    = q_job_i.irq_level;
      if (q_job_i.frame_done) begin
        out_d.read_data    = '0;
        out_d.spi_valid    = 1'b1;
        out_d.spi_word     = phase_q ? q_job_i.frame[31:0] : q_job_i.frame[63:32];
        out_d.chip_select  = q_job_i.chip_select;
        out_d.select_error = q_job_i.select_error;
        out_d.last         = phase_q;
        phase_d            = !phase_q;
      end else begin
        out_d.read_data    = q_job_i.read_data;
        out_d.spi_valid    = 1'b0;
        out_d.spi_word     = '0;
        out_d.chip_select  = 2'd0;
        out_d.select_error = 1'b0;
        out_d.last         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/uart_frame_to_spi_bridge_unit.sv =====
// An accepted access is registered in the job queue, then in the output register.
// Throughput: one access per cycle while the job queue is not full; a completed
// frame yields two output items (two SPI words) through the single output register.
// The job queue holds QUEUE_DEPTH entries between front and back.
// Reset (async, active low) loads register reset values, empties the queue.
`timescale 1ns / 1ps
`default_nettype none

`include "uart_frame_to_spi_bridge_unit_macros.svh"

module uart_frame_to_spi_bridge_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ufsb_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ufsb_pkg::out_item_t    out_item_o
);

  logic           q_full, q_empty, q_push, q_pop;
  ufsb_pkg::job_t q_in, q_out;

  ufsb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_in)
  );

  ufsb_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  ufsb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `UFSB_ASSERT(a_plain_is_last, clk_i, rst_ni, out_valid_o && !out_item_o.spi_valid |-> out_item_o.last, "plain item without last")
  `UFSB_ASSERT(a_err_no_cs, clk_i, rst_ni, out_valid_o && out_item_o.select_error |-> out_item_o.chip_select == 2'd0, "select asserted on error")
  `UFSB_ASSERT(a_second_word, clk_i, rst_ni, out_valid_o && out_ready_i && out_item_o.spi_valid && !out_item_o.last |=> out_valid_o && out_item_o.spi_valid && out_item_o.last, "second SPI word missing")
  `UFSB_ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_full, "push into full queue")

endmodule

`default_nettype wire
